// File: hw/rtl/quaternion_vector_rotate_unit_assert.svh
// Assertion macros used by the rotation unit's top-level RTL file.
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QVR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/qvr_pkg.sv
`timescale 1ns / 1ps

package qvr_pkg;

	localparam int unsigned DATA_W = 32;
	// Exact product of two Q2.30 values (Q4.60).
	localparam int unsigned PROD_W = 2 * DATA_W;
	// A rotation term is the sum of two products.
	localparam int unsigned COEF_W = PROD_W + 1;
	localparam int unsigned AXES = 3;

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic [AXES-1:0][COEF_W-1:0] coef_row_t;
	typedef logic [AXES-1:0][DATA_W-1:0] vec3_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic signed [DATA_W-1:0] rot_z;
	} out_item_t;

endpackage

// File: hw/rtl/qvr_row.sv
`timescale 1ns / 1ps

module qvr_row (
	input  logic             clk,
	input  logic             ce,
	input  qvr_pkg::coef_row_t coef,
	input  qvr_pkg::vec3_t   vec,
	input  qvr_pkg::fix_t    vown,
	output qvr_pkg::fix_t    rot
);
	import qvr_pkg::*;

	localparam int unsigned HI_W   = COEF_W - DATA_W;
	localparam int unsigned PP_W   = COEF_W;
	localparam int unsigned MUL_W  = COEF_W + DATA_W;
	localparam int unsigned ACC_W  = MUL_W + 2;
	localparam int unsigned FRAC   = 2 * (DATA_W - 2);
	localparam int unsigned FIN_W  = ACC_W + 2;
	localparam int unsigned Q_W    = FIN_W - FRAC;

	logic signed [PP_W-1:0]  lo_pp_s3 [AXES];
	logic signed [PP_W-1:0]  hi_pp_s3 [AXES];
	logic signed [MUL_W-1:0] prod_s4 [AXES];
	logic signed [ACC_W-1:0] acc_s5;
	fix_t                    vown_s3, vown_s4, vown_s5;
	fix_t                    rot_s6;

	logic signed [FIN_W-1:0] fin;
	logic signed [Q_W-1:0]   q;

	// The 65-bit coefficient is split into an unsigned low word and a signed
	// high part so that each multiplier stays near 33 by 32 bits.
	always_ff @(posedge clk) begin
		if (ce) begin
			for (int j = 0; j < AXES; j++) begin
				lo_pp_s3[j] <= $signed({1'b0, coef[j][DATA_W-1:0]}) * $signed(vec[j]);
				hi_pp_s3[j] <= $signed(coef[j][COEF_W-1:DATA_W]) * $signed(vec[j]);
			end
			vown_s3 <= vown;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int j = 0; j < AXES; j++) begin
				prod_s4[j] <= $signed({hi_pp_s3[j][HI_W+DATA_W-1:0], {DATA_W{1'b0}}})
					+ $signed({{DATA_W{lo_pp_s3[j][PP_W-1]}}, lo_pp_s3[j]});
			end
			vown_s4 <= vown_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			acc_s5 <= $signed({{2{prod_s4[0][MUL_W-1]}}, prod_s4[0]})
				+ $signed({{2{prod_s4[1][MUL_W-1]}}, prod_s4[1]})
				+ $signed({{2{prod_s4[2][MUL_W-1]}}, prod_s4[2]});
			vown_s5 <= vown_s4;
		end
	end

	// Double the sum, add the vector aligned to the product format, then
	// round to nearest with ties toward plus infinity.
	always_comb begin
		fin = $signed({acc_s5[ACC_W-1], acc_s5, 1'b0})
			+ $signed({{(FIN_W-DATA_W-FRAC){vown_s5[DATA_W-1]}}, vown_s5, {FRAC{1'b0}}})
			+ $signed({{(FIN_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}});
		q = fin[FIN_W-1:FRAC];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (q > $signed({{(Q_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}})) begin
				rot_s6 <= {1'b0, {(DATA_W-1){1'b1}}};
			end else if (q < $signed({{(Q_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}})) begin
				rot_s6 <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				rot_s6 <= q[DATA_W-1:0];
			end
		end
	end

	assign rot = rot_s6;

endmodule

// File: hw/rtl/quaternion_vector_rotate_unit.sv
`timescale 1ns / 1ps
// Data path: an accepted input item enters s1 and advances through s2 to s5 into the output
// register s6, where its result waits until out_ready takes it.
// Throughput: one item per cycle; the six register stages advance together and
// the whole pipeline holds while the output item waits for out_ready.
// Reset: arst_n clears the stage valid bits asynchronously; data registers are not reset.
`include "quaternion_vector_rotate_unit_assert.svh"

module quaternion_vector_rotate_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qvr_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output qvr_pkg::out_item_t out_item
);
	import qvr_pkg::*;

	// Stage map:
	//   s1: the nine pairwise quaternion products, each an exact Q4.60 value.
	//   s2: the nine rotation matrix terms, each a sum of two products.
	//   s3: partial products of each term with a vector component.
	//   s4: partial products joined into full term-times-component products.
	//   s5: the three products of each row summed.
	//   s6: doubling, vector add, rounding and saturation into the output register.
	// Stages s3 to s6 live in one qvr_row instance per output component.

	logic ce;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [PROD_W-1:0] xw_s1, yw_s1, zw_s1, xx_s1, xy_s1, xz_s1, yy_s1, yz_s1, zz_s1;
	vec3_t     vec_s1, vec_s2;
	coef_row_t row_x_s2, row_y_s2, row_z_s2;
	fix_t      rot_x, rot_y, rot_z;

	// Every stage moves when the output register is empty or being drained.
	assign ce       = !vld_s6 || out_ready;
	assign in_ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			xw_s1 <= $signed(in_item.quat_w) * $signed(in_item.quat_x);
			yw_s1 <= $signed(in_item.quat_w) * $signed(in_item.quat_y);
			zw_s1 <= $signed(in_item.quat_w) * $signed(in_item.quat_z);
			xx_s1 <= $signed(in_item.quat_x) * $signed(in_item.quat_x);
			xy_s1 <= $signed(in_item.quat_x) * $signed(in_item.quat_y);
			xz_s1 <= $signed(in_item.quat_x) * $signed(in_item.quat_z);
			yy_s1 <= $signed(in_item.quat_y) * $signed(in_item.quat_y);
			yz_s1 <= $signed(in_item.quat_y) * $signed(in_item.quat_z);
			zz_s1 <= $signed(in_item.quat_z) * $signed(in_item.quat_z);
			vec_s1 <= {in_item.vec_z, in_item.vec_y, in_item.vec_x};
		end
	end

	// Sign-extend a product to the term width.
	function automatic logic signed [COEF_W-1:0] ext(input logic signed [PROD_W-1:0] p);
		ext = $signed({p[PROD_W-1], p});
	endfunction

	// Rows of M, indexed by the vector component that multiplies each term.
	always_ff @(posedge clk) begin
		if (ce) begin
			row_x_s2[0] <= -ext(yy_s1) - ext(zz_s1);
			row_x_s2[1] <= ext(xy_s1) - ext(zw_s1);
			row_x_s2[2] <= ext(yw_s1) + ext(xz_s1);
			row_y_s2[0] <= ext(zw_s1) + ext(xy_s1);
			row_y_s2[1] <= -ext(xx_s1) - ext(zz_s1);
			row_y_s2[2] <= ext(yz_s1) - ext(xw_s1);
			row_z_s2[0] <= ext(xz_s1) - ext(yw_s1);
			row_z_s2[1] <= ext(xw_s1) + ext(yz_s1);
			row_z_s2[2] <= -ext(xx_s1) - ext(yy_s1);
			vec_s2 <= vec_s1;
		end
	end

	qvr_row u_row_x (
		.clk  (clk),
		.ce   (ce),
		.coef (row_x_s2),
		.vec  (vec_s2),
		.vown (vec_s2[0]),
		.rot  (rot_x)
	);

	qvr_row u_row_y (
		.clk  (clk),
		.ce   (ce),
		.coef (row_y_s2),
		.vec  (vec_s2),
		.vown (vec_s2[1]),
		.rot  (rot_y)
	);

	qvr_row u_row_z (
		.clk  (clk),
		.ce   (ce),
		.coef (row_z_s2),
		.vec  (vec_s2),
		.vown (vec_s2[2]),
		.rot  (rot_z)
	);

	assign out_valid      = vld_s6;
	assign out_item.rot_x = rot_x;
	assign out_item.rot_y = rot_y;
	assign out_item.rot_z = rot_z;

	// An accepted item occupies the first stage on the next cycle.
	`QVR_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, vld_s1, "accepted item lost at stage one")
	// A stalled pipeline keeps its middle items in place.
	`QVR_ASSERT_NEXT(a_stall_holds_s3, clk, arst_n, !ce && vld_s3, vld_s3 && vld_s4 == $past(vld_s4), "stalled stage changed")
	// An advancing item in the last inner stage reaches the output register.
	`QVR_ASSERT_NEXT(a_s5_reaches_out, clk, arst_n, ce && vld_s5, out_valid, "item lost before output")

endmodule
